FILE: design/bctc_pkg.sv
// ----------------------------------------------------------------------------
// Block cache tag controller package
// Shared constants and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package bctc_pkg;

  // Replacement policy codes held in the configuration register.
  localparam int POLICY_W = 2;
  localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_LRU  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_LFU  = 2'd2;

  // Fixed field widths of the result and of the entry stamp.
  localparam int SLOT_W  = 2;
  localparam int STAMP_W = 32;
  localparam int TOTAL_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture an accepted request
    logic lookup;     // parallel tag compare
    logic choose;     // pick hit slot, free slot, FIFO victim or start scan
    logic scan_step;  // compare one more entry in the victim scan
    logic commit;     // update entry state and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_needed;  // miss on a full cache under LRU or LFU
    logic scan_last;    // the scan is looking at the last entry
  } status_t;

endpackage

FILE: design/bctc_req_if.sv
// ----------------------------------------------------------------------------
// Block cache request channel
// Valid/ready channel that carries one read or write request.
// ----------------------------------------------------------------------------
interface bctc_req_if #(
  parameter int BLOCK_BITS = 19
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [BLOCK_BITS-1:0] block_number;

  modport source (output valid, output kind, output block_number, input ready);
  modport sink (input valid, input kind, input block_number, output ready);
endinterface

FILE: design/bctc_rsp_if.sv
// ----------------------------------------------------------------------------
// Block cache result channel
// Valid/ready channel that carries the lookup result of one request.
// ----------------------------------------------------------------------------
interface bctc_rsp_if #(
  parameter int BLOCK_BITS = 19
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [bctc_pkg::SLOT_W-1:0]  slot;
  logic                         writeback;
  logic [BLOCK_BITS-1:0]        writeback_block;
  logic [bctc_pkg::TOTAL_W-1:0] hit_total;

  modport source (
    output valid, output hit, output slot, output writeback,
    output writeback_block, output hit_total, input ready
  );
  modport sink (
    input valid, input hit, input slot, input writeback,
    input writeback_block, input hit_total, output ready
  );
endinterface

FILE: design/bctc_ctrl.sv
// ----------------------------------------------------------------------------
// Block cache tag controller sequencer
// Steps one request through lookup, victim choice, optional scan and commit.
// ----------------------------------------------------------------------------
module bctc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output bctc_pkg::cmd_t    cmd,
  input  bctc_pkg::status_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHOOSE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_CHOOSE;
      end
      ST_CHOOSE: begin
        cmd.choose = 1'b1;
        state_next = sts.scan_needed ? ST_SCAN : ST_COMMIT;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/bctc_datapath.sv
// ----------------------------------------------------------------------------
// Block cache tag controller datapath
// Entry tags and metadata, tag compare, victim scan and the result register.
// ----------------------------------------------------------------------------
module bctc_datapath #(
  parameter int ENTRIES    = 4,
  parameter int BLOCK_BITS = 19,
  parameter int USE_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bctc_pkg::POLICY_W-1:0]       cfg_data,
  input  logic                                req_kind,
  input  logic [BLOCK_BITS-1:0]               req_block,
  input  bctc_pkg::cmd_t                      cmd,
  output bctc_pkg::status_t                   sts,
  output logic                                rsp_hit,
  output logic [bctc_pkg::SLOT_W-1:0]         rsp_slot,
  output logic                                rsp_writeback,
  output logic [BLOCK_BITS-1:0]               rsp_writeback_block,
  output logic [bctc_pkg::TOTAL_W-1:0]        rsp_hit_total
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam logic [USE_BITS-1:0] USE_MAX = {USE_BITS{1'b1}};
  localparam logic [bctc_pkg::TOTAL_W-1:0] TOTAL_MAX = {bctc_pkg::TOTAL_W{1'b1}};

  // Configuration and per-entry state.
  logic [bctc_pkg::POLICY_W-1:0] policy;
  logic [ENTRIES-1:0]            entry_valid;
  logic [ENTRIES-1:0]            entry_dirty;
  logic [BLOCK_BITS-1:0]         entry_block [ENTRIES];
  logic [USE_BITS-1:0]           entry_uses  [ENTRIES];
  logic [bctc_pkg::STAMP_W-1:0]  entry_stamp [ENTRIES];
  logic [bctc_pkg::STAMP_W-1:0]  use_clock;
  logic [FILL_W-1:0]             fill_count;
  logic [IDX_W-1:0]              fifo_pointer;
  logic [bctc_pkg::TOTAL_W-1:0]  hit_counter;

  // Per-request working registers.
  logic                          kind;
  logic [BLOCK_BITS-1:0]         block;
  logic                          hit;
  logic [IDX_W-1:0]              hit_idx;
  logic [IDX_W-1:0]              target;
  logic [IDX_W-1:0]              scan_idx;
  logic [bctc_pkg::STAMP_W-1:0]  best_key;

  logic                          full;
  logic                          by_scan;
  logic [ENTRIES-1:0]            match;
  logic                          match_any;
  logic [IDX_W-1:0]              match_idx;
  logic [bctc_pkg::STAMP_W-1:0]  first_key;
  logic [bctc_pkg::STAMP_W-1:0]  scan_key;
  logic [USE_BITS-1:0]           target_uses;
  logic [USE_BITS-1:0]           uses_new;
  logic [bctc_pkg::STAMP_W-1:0]  clock_new;
  logic                          dirty_new;
  logic                          evict_dirty;

  assign full    = (fill_count == FILL_W'(ENTRIES));
  assign by_scan = policy inside {bctc_pkg::POLICY_LRU, bctc_pkg::POLICY_LFU};

  // Parallel tag compare with the lowest matching entry taking priority.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_block[i] == block);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
    end
  end
  assign match_any = |match;

  // Replacement key: stamp for LRU, use count for LFU.
  assign first_key = (policy == bctc_pkg::POLICY_LRU) ? entry_stamp[0]
                                                       : bctc_pkg::STAMP_W'(entry_uses[0]);
  assign scan_key  = (policy == bctc_pkg::POLICY_LRU) ? entry_stamp[scan_idx]
                                                       : bctc_pkg::STAMP_W'(entry_uses[scan_idx]);

  assign sts.scan_needed = !hit && full && by_scan && (ENTRIES > 1);
  assign sts.scan_last   = (scan_idx == IDX_W'(ENTRIES - 1));

  // New metadata for the slot being accessed.
  assign target_uses = hit ? entry_uses[target] : '0;
  assign uses_new    = (target_uses == USE_MAX) ? target_uses : target_uses + 1'b1;
  assign clock_new   = use_clock + 1'b1;
  assign dirty_new   = kind || (hit && entry_dirty[target]);
  assign evict_dirty = !hit && full && entry_valid[target] && entry_dirty[target];

  // Request capture, lookup and victim choice.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind  <= req_kind;
      block <= req_block;
    end
    if (cmd.lookup) begin
      hit     <= match_any;
      hit_idx <= match_idx;
    end
    if (cmd.choose) begin
      scan_idx <= IDX_W'(1);
      best_key <= first_key;
      if (hit) begin
        target <= hit_idx;
      end else if (!full) begin
        target <= IDX_W'(fill_count);
      end else if (by_scan) begin
        target <= '0;
      end else begin
        target <= fifo_pointer;
      end
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (scan_key < best_key) begin
        best_key <= scan_key;
        target   <= scan_idx;
      end
    end
  end

  // Entry state, counters and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= bctc_pkg::POLICY_FIFO;
      entry_valid  <= '0;
      entry_dirty  <= '0;
      use_clock    <= '0;
      fill_count   <= '0;
      fifo_pointer <= '0;
      hit_counter  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_uses[i]  <= '0;
        entry_stamp[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        policy <= cfg_data;
      end
      if (cmd.commit) begin
        entry_valid[target] <= 1'b1;
        entry_dirty[target] <= dirty_new;
        entry_uses[target]  <= uses_new;
        entry_stamp[target] <= clock_new;
        use_clock           <= clock_new;
        if (hit) begin
          if (hit_counter != TOTAL_MAX) begin
            hit_counter <= hit_counter + 1'b1;
          end
        end else if (!full) begin
          fill_count <= fill_count + 1'b1;
        end else if (!by_scan) begin
          fifo_pointer <= (fifo_pointer == IDX_W'(ENTRIES - 1)) ? '0
                                                                 : fifo_pointer + 1'b1;
        end
      end
    end
  end

  // Tag write and the result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (!hit) begin
        entry_block[target] <= block;
      end
      rsp_hit             <= hit;
      rsp_slot            <= bctc_pkg::SLOT_W'(target);
      rsp_writeback       <= evict_dirty;
      rsp_writeback_block <= evict_dirty ? entry_block[target] : '0;
      rsp_hit_total       <= (hit && (hit_counter != TOTAL_MAX)) ? hit_counter + 1'b1
                                                                 : hit_counter;
    end
  end

endmodule

FILE: design/block_cache_tag_controller_unit.sv
// ----------------------------------------------------------------------------
// Block cache tag controller
// Tag and metadata controller for a small fully associative write-back cache.
// ----------------------------------------------------------------------------
// Each request steps through capture, parallel tag compare, slot choice and
// commit, each a sequencer state; commit loads the output register, and the
// next request is taken once the sequencer is back in idle. When a miss finds
// every entry in use and the policy is LRU or LFU, a victim scan between slot
// choice and commit compares one entry's stamp or use count per cycle. A new
// request is taken while the previous result still waits in the output
// register; commit stalls only if that register has not yet been read. The
// user must write the policy register (0 FIFO, 1 LRU, 2 LFU, 3 as FIFO) only
// while no request is in flight; the block itself does not enforce this.
module block_cache_tag_controller_unit #(
  parameter int ENTRIES    = 4,
  parameter int BLOCK_BITS = 19,
  parameter int USE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bctc_pkg::POLICY_W-1:0] cfg_data,
  bctc_req_if.sink                      req,
  bctc_rsp_if.source                    rsp
);

  bctc_pkg::cmd_t    cmd;
  bctc_pkg::status_t sts;

  // Request sequencer.
  bctc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Tags, metadata and result register.
  bctc_datapath #(
    .ENTRIES    (ENTRIES),
    .BLOCK_BITS (BLOCK_BITS),
    .USE_BITS   (USE_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_data),
    .req_kind            (req.kind),
    .req_block           (req.block_number),
    .cmd                 (cmd),
    .sts                 (sts),
    .rsp_hit             (rsp.hit),
    .rsp_slot            (rsp.slot),
    .rsp_writeback       (rsp.writeback),
    .rsp_writeback_block (rsp.writeback_block),
    .rsp_hit_total       (rsp.hit_total)
  );

endmodule
